/* hw/rtl/chc_pkg.sv */
// Shared types, constants and small lookup functions for the compass heading block.
// Used by chc_calib, chc_cordic and compass_heading_with_calibration.
package chc_pkg;

	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int IN_BITS          = 16;   // width of the sample ports
	localparam int ANGLE_BITS       = 23;   // unsigned Q16 degrees, 0..90<<16
	localparam int Z_BITS           = 24;   // signed angle accumulator
	localparam int RAW_BITS         = 25;   // Q16 raw heading, 0..360<<16
	localparam int HEAD_BITS        = 9;
	localparam int CODE_BITS        = 3;
	localparam int DECL_BITS        = 9;
	localparam int SUM_BITS         = 11;   // raw heading plus declination, signed
	localparam int ATAN_IDX_BITS    = 5;

	localparam logic [DECL_BITS-1:0]  DECL_RESET = 9'd15;
	localparam logic [RAW_BITS-1:0]   DEG90_Q16  = 25'd5898240;
	localparam logic [RAW_BITS-1:0]   DEG270_Q16 = 25'd17694720;
	localparam logic [SUM_BITS-1:0]   FULL_TURN  = 11'd360;

	typedef struct packed {
		logic x_below;  // sample x under its midpoint
		logic y_above;  // sample y over its midpoint
		logic y_below;  // sample y under its midpoint
	} quad_t;

	typedef struct packed {
		logic done;
		logic busy;
	} cordic_stat_t;

	// atan(2^-i) in Q16 degrees
	function automatic logic [ANGLE_BITS-1:0] atan_q16(input logic [ATAN_IDX_BITS-1:0] idx);
		logic [ANGLE_BITS-1:0] v;
		case (idx)
			5'd0:  v = 23'd2949120;
			5'd1:  v = 23'd1740967;
			5'd2:  v = 23'd919879;
			5'd3:  v = 23'd466945;
			5'd4:  v = 23'd234379;
			5'd5:  v = 23'd117304;
			5'd6:  v = 23'd58666;
			5'd7:  v = 23'd29335;
			5'd8:  v = 23'd14668;
			5'd9:  v = 23'd7334;
			5'd10: v = 23'd3667;
			5'd11: v = 23'd1833;
			5'd12: v = 23'd917;
			5'd13: v = 23'd458;
			5'd14: v = 23'd229;
			5'd15: v = 23'd115;
			5'd16: v = 23'd57;
			5'd17: v = 23'd29;
			5'd18: v = 23'd14;
			5'd19: v = 23'd7;
			5'd20: v = 23'd4;
			5'd21: v = 23'd2;
			5'd22: v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

	// eight-way sector: north wraps around at 338
	function automatic logic [CODE_BITS-1:0] sector(input logic [HEAD_BITS-1:0] h);
		logic [CODE_BITS-1:0] c;
		if (h >= 9'd338)      c = 3'd0;
		else if (h >= 9'd293) c = 3'd7;
		else if (h >= 9'd248) c = 3'd6;
		else if (h >= 9'd203) c = 3'd5;
		else if (h >= 9'd158) c = 3'd4;
		else if (h >= 9'd113) c = 3'd3;
		else if (h >= 9'd68)  c = 3'd2;
		else if (h >= 9'd23)  c = 3'd1;
		else                  c = 3'd0;
		return c;
	endfunction

endpackage

/* hw/rtl/chc_calib.sv */
// Hard-iron calibration: running per-axis min/max, midpoints and sample offsets.
// Depends on chc_pkg.
module chc_calib #(
	parameter int SAMPLE_BITS = chc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,     // sample transfer
	input  logic                          mid_en,   // latch midpoints
	input  logic [chc_pkg::IN_BITS-1:0]   x_in,
	input  logic [chc_pkg::IN_BITS-1:0]   y_in,
	output logic [SAMPLE_BITS-1:0]        tx,
	output logic [SAMPLE_BITS-1:0]        ty,
	output chc_pkg::quad_t                quad
);

	localparam logic [SAMPLE_BITS-1:0] CENTER = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [SAMPLE_BITS-1:0] xs, ys;
	logic [SAMPLE_BITS-1:0] xs_q, ys_q;
	logic [SAMPLE_BITS-1:0] x_max_q, x_min_q, y_max_q, y_min_q;
	logic [SAMPLE_BITS-1:0] mid_x_q, mid_y_q;

	assign xs = SAMPLE_BITS'(x_in);
	assign ys = SAMPLE_BITS'(y_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_max_q <= CENTER;
			x_min_q <= CENTER;
			y_max_q <= CENTER;
			y_min_q <= CENTER;
		end else if (load) begin
			if (xs > x_max_q) x_max_q <= xs;
			if (xs < x_min_q) x_min_q <= xs;
			if (ys > y_max_q) y_max_q <= ys;
			if (ys < y_min_q) y_min_q <= ys;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			xs_q <= xs;
			ys_q <= ys;
		end
		if (mid_en) begin
			mid_x_q <= (x_max_q >> 1) + (x_min_q >> 1);
			mid_y_q <= (y_max_q >> 1) + (y_min_q >> 1);
		end
	end

	always_comb begin
		quad.x_below = xs_q < mid_x_q;
		quad.y_above = ys_q > mid_y_q;
		quad.y_below = ys_q < mid_y_q;
		tx = quad.x_below ? mid_x_q - xs_q : xs_q - mid_x_q;
		ty = quad.y_below ? mid_y_q - ys_q : ys_q - mid_y_q;
	end

endmodule

/* hw/rtl/chc_cordic.sv */
// Iterative CORDIC vectoring unit: atan(ty/tx) in Q16 degrees, one step per cycle.
// Depends on chc_pkg for the arctangent table and angle widths.
module chc_cordic #(
	parameter int SAMPLE_BITS  = chc_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = chc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [SAMPLE_BITS-1:0]            tx,
	input  logic [SAMPLE_BITS-1:0]            ty,
	output chc_pkg::cordic_stat_t             stat,
	output logic [chc_pkg::ANGLE_BITS-1:0]    angle
);

	localparam int W  = SAMPLE_BITS + 19;
	localparam int CW = $clog2(CORDIC_STEPS);
	localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);
	localparam logic signed [chc_pkg::Z_BITS-1:0] Z90 =
		chc_pkg::Z_BITS'(chc_pkg::DEG90_Q16);

	logic signed [W-1:0]              x_q, y_q, dx, dy;
	logic signed [chc_pkg::Z_BITS-1:0] z_q, t;
	logic [CW-1:0]                    i_q;
	logic                             busy_q, done_q;

	// shared shift/add unit
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign t  = signed'({1'b0, chc_pkg::atan_q16(chc_pkg::ATAN_IDX_BITS'(i_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				i_q <= '0;
				if (ty == '0 || tx == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= signed'({3'b000, tx, 16'h0000});
			y_q <= signed'({3'b000, ty, 16'h0000});
			if (ty == '0)      z_q <= '0;
			else if (tx == '0) z_q <= Z90;
			else               z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + t;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - t;
			end
		end
	end

	always_comb begin
		if (z_q[chc_pkg::Z_BITS-1])
			angle = '0;
		else if (z_q > Z90)
			angle = chc_pkg::ANGLE_BITS'(Z90);
		else
			angle = z_q[chc_pkg::ANGLE_BITS-1:0];
	end

	assign stat.done = done_q;
	assign stat.busy = busy_q;

endmodule

/* hw/rtl/compass_heading_with_calibration.sv */
// Compass heading with running hard-iron calibration: top level, sequencer and output.
// Depends on chc_pkg, chc_calib and chc_cordic.
//
// Use:
//   Sample channel: sample_valid / sample_stall with x_sample, y_sample. A transfer
//   happens when sample_valid is high and sample_stall low. sample_stall is high
//   from the transfer until the item has been handed to the output register.
//   Result channel: heading_valid / heading_stall with heading_deg (0..359) and
//   direction_code (0 N .. 7 NW). The receiver holds heading_stall high to wait;
//   the result stays in the output register and the next sample may already be
//   taken, but it then waits at its last step until the register is free.
//   Config channel: cfg_valid / cfg_ready with declination_deg (signed degrees);
//   cfg_ready is always high. Write only while no item is in flight.
// Sequence:
//   After a transfer the sequencer latches the midpoints, starts the CORDIC, waits for
//   its iterations in the single shared shift/add unit, then adds declination, wraps,
//   finds the sector and loads the output register. A zero y or x offset skips the
//   iterations. One sample at a time is in flight; the next transfer can be taken
//   as soon as the result is loaded into the output register, while heading_valid
//   is high.
// Reset:
//   arst_n clears the min/max trackers to the center code, declination to 15,
//   and empties the output register.
module compass_heading_with_calibration #(
	parameter int SAMPLE_BITS  = chc_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = chc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  logic [chc_pkg::IN_BITS-1:0]      x_sample,
	input  logic [chc_pkg::IN_BITS-1:0]      y_sample,
	output logic                             heading_valid,
	input  logic                             heading_stall,
	output logic [chc_pkg::HEAD_BITS-1:0]    heading_deg,
	output logic [chc_pkg::CODE_BITS-1:0]    direction_code,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [chc_pkg::DECL_BITS-1:0]    declination_deg
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a sample
	localparam logic [2:0] ST_MID  = 3'd1;  // trackers updated, latch midpoints
	localparam logic [2:0] ST_OFFS = 3'd2;  // offsets ready, kick the CORDIC
	localparam logic [2:0] ST_WAIT = 3'd3;  // CORDIC iterating
	localparam logic [2:0] ST_HEAD = 3'd4;  // declination, wrap, sector, output

	logic [2:0]                       state_q;
	logic                             sample_xfer, out_free;
	logic [chc_pkg::DECL_BITS-1:0]    decl_q;
	logic [chc_pkg::HEAD_BITS-1:0]    raw_deg_q;
	logic [SAMPLE_BITS-1:0]           tx, ty;
	chc_pkg::quad_t                   quad;
	chc_pkg::cordic_stat_t            cstat;
	logic [chc_pkg::ANGLE_BITS-1:0]   angle;
	logic [chc_pkg::RAW_BITS-1:0]     base, raw_q16;
	logic signed [chc_pkg::SUM_BITS-1:0] sum;
	logic [chc_pkg::SUM_BITS-1:0]     wrapped;
	logic [chc_pkg::HEAD_BITS-1:0]    head;
	logic                             out_valid_q;
	logic [chc_pkg::HEAD_BITS-1:0]    head_q;
	logic [chc_pkg::CODE_BITS-1:0]    code_q;

	assign sample_stall = (state_q != ST_IDLE);
	assign sample_xfer  = sample_valid && !sample_stall;
	assign out_free     = !out_valid_q || !heading_stall;
	assign cfg_ready    = 1'b1;

	chc_calib #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_calib (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (sample_xfer),
		.mid_en (state_q == ST_MID),
		.x_in   (x_sample),
		.y_in   (y_sample),
		.tx     (tx),
		.ty     (ty),
		.quad   (quad)
	);

	chc_cordic #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_OFFS),
		.tx     (tx),
		.ty     (ty),
		.stat   (cstat),
		.angle  (angle)
	);

	// quadrant mapping: 90 -/+ a when x is under its midpoint, else 270 -/+ a
	always_comb begin
		base = quad.x_below ? chc_pkg::DEG90_Q16 : chc_pkg::DEG270_Q16;
		if (quad.x_below ? quad.y_above : quad.y_below)
			raw_q16 = base - chc_pkg::RAW_BITS'(angle);
		else
			raw_q16 = base + chc_pkg::RAW_BITS'(angle);
	end

	// add declination and wrap into 0..359; the sum stays within -256..615
	always_comb begin
		sum = signed'({2'b00, raw_deg_q}) + chc_pkg::SUM_BITS'(signed'(decl_q));
		if (sum[chc_pkg::SUM_BITS-1])
			wrapped = unsigned'(sum) + chc_pkg::FULL_TURN;
		else if (unsigned'(sum) >= chc_pkg::FULL_TURN)
			wrapped = unsigned'(sum) - chc_pkg::FULL_TURN;
		else
			wrapped = unsigned'(sum);
		head = wrapped[chc_pkg::HEAD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			decl_q      <= chc_pkg::DECL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				decl_q <= declination_deg;
			// load wins over the drain of the previous result
			if (state_q == ST_HEAD && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !heading_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (sample_xfer)
						state_q <= ST_MID;
				end
				ST_MID:  state_q <= ST_OFFS;
				ST_OFFS: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (cstat.done)
						state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && cstat.done)
			raw_deg_q <= raw_q16[chc_pkg::RAW_BITS-1:16];
		if (state_q == ST_HEAD && out_free) begin
			head_q <= head;
			code_q <= chc_pkg::sector(head);
		end
	end

	assign heading_valid  = out_valid_q;
	assign heading_deg    = head_q;
	assign direction_code = code_q;

`ifndef SYNTHESIS
	a_xfer_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sample_xfer |=> state_q == ST_MID)
		else $error("sample transfer did not start the sequencer");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cstat.done |-> state_q == ST_WAIT)
		else $error("CORDIC finished outside its wait state");

	a_no_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cstat.busy |-> state_q == ST_WAIT)
		else $error("CORDIC iterating while sequencer not waiting");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		heading_valid |-> heading_deg < 9'd360)
		else $error("heading out of range");

	a_north_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		heading_valid && heading_deg >= 9'd338 |-> direction_code == 3'd0)
		else $error("north sector wrong near 360");
`endif

endmodule

/* dv/compass_heading_with_calibration_test.sv */
// Self-checking testbench for compass_heading_with_calibration.
// Drives x/y samples and declination writes, checks heading and sector against an
// in-bench predictor. Needs chc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module compass_heading_with_calibration_test;

	localparam int         SAMPLE_W    = chc_pkg::IN_BITS;
	localparam int         CORDIC_ITER = chc_pkg::CORDIC_STEPS_DEF;
	localparam longint     Q16_90      = 90 * 65536;
	localparam int         DRAIN_CYC   = 3 * (chc_pkg::CORDIC_STEPS_DEF + 4);
	localparam logic [SAMPLE_W-1:0] CENTER = 16'h8000;

	// atan(2^-i) in Q16 degrees, one entry per vectoring step
	localparam longint ATAN_DEG_Q16 [0:15] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	typedef struct packed {
		logic [chc_pkg::HEAD_BITS-1:0] heading;
		logic [chc_pkg::CODE_BITS-1:0] sector;
	} heading_t;

	typedef enum logic [1:0] {
		STALL_OFF,
		STALL_SPARSE,
		STALL_HEAVY,
		STALL_PULSED
	} stall_mode_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  sample_valid   = 1'b0;
	logic                  sample_stall;
	logic [SAMPLE_W-1:0]   x_sample       = '0;
	logic [SAMPLE_W-1:0]   y_sample       = '0;
	logic                  heading_valid;
	logic                  heading_stall  = 1'b0;
	logic [chc_pkg::HEAD_BITS-1:0]  heading_deg;
	logic [chc_pkg::CODE_BITS-1:0]  direction_code;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	logic [chc_pkg::DECL_BITS-1:0]  declination_deg = '0;

	// predictor state: calibration trackers and the declination register
	logic [SAMPLE_W-1:0]   x_max, x_min, y_max, y_min;
	int                    declination_model;
	heading_t              pending_headings [$];

	int mismatch_count   = 0;
	int samples_sent     = 0;
	int headings_checked = 0;
	int decl_writes      = 0;
	int burst_left       = 1;
	bit valid_on         = 1'b0;

	compass_heading_with_calibration i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.x_sample       (x_sample),
		.y_sample       (y_sample),
		.heading_valid  (heading_valid),
		.heading_stall  (heading_stall),
		.heading_deg    (heading_deg),
		.direction_code (direction_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.declination_deg(declination_deg)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("Timeout: %0d headings still pending", pending_headings.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// vectoring CORDIC on the absolute offsets, angle in Q16 degrees 0..90
	function automatic longint cordic_angle(input longint off_x, input longint off_y);
		longint vx, vy, ang, dx, dy;
		int     i;
		ang = 0;
		if (off_y == 0)
			return 0;
		if (off_x == 0)
			return Q16_90;
		vx = off_x <<< 16;
		vy = off_y <<< 16;
		for (i = 0; i < CORDIC_ITER; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx;
				vy -= dy;
				ang += ATAN_DEG_Q16[i];
			end else begin
				vx -= dx;
				vy += dy;
				ang -= ATAN_DEG_Q16[i];
			end
		end
		if (ang < 0)
			ang = 0;
		if (ang > Q16_90)
			ang = Q16_90;
		return ang;
	endfunction

	// widens the trackers, then forms heading and sector for one sample pair
	function automatic heading_t predict_heading(input logic [SAMPLE_W-1:0] xs,
	                                             input logic [SAMPLE_W-1:0] ys);
		longint   xv, yv, mid_x, mid_y, off_x, off_y, ang, raw, hdg;
		heading_t r;
		xv = longint'(xs);
		yv = longint'(ys);
		if (xs > x_max) x_max = xs;
		if (ys > y_max) y_max = ys;
		if (xs < x_min) x_min = xs;
		if (ys < y_min) y_min = ys;
		mid_x = longint'(x_max >> 1) + longint'(x_min >> 1);
		mid_y = longint'(y_max >> 1) + longint'(y_min >> 1);
		off_x = (xv < mid_x) ? mid_x - xv : xv - mid_x;
		off_y = (yv < mid_y) ? mid_y - yv : yv - mid_y;
		ang   = cordic_angle(off_x, off_y);
		if (xv < mid_x)
			raw = (yv > mid_y) ? Q16_90 - ang : Q16_90 + ang;
		else
			raw = (yv < mid_y) ? 3 * Q16_90 - ang : 3 * Q16_90 + ang;
		raw = raw >>> 16;
		// C-style remainder, then fold negatives up; 360 lands on 0 here
		hdg = (raw + declination_model) % 360;
		if (hdg < 0)
			hdg += 360;
		r.heading = hdg[chc_pkg::HEAD_BITS-1:0];
		r.sector  = (hdg >= 338) ? '0 : chc_pkg::CODE_BITS'((2 * hdg + 45) / 90);
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("[%0t] heading check: %s: got %0d, want %0d", $time, what, got, want);
	endtask

	// result side: compare every transfer with the oldest pending heading,
	// and stall on a pattern that switches to a random mode when its countdown runs out
	stall_mode_t stall_mode = STALL_OFF;
	int          stall_left = 100;
	int unsigned rx_cycle   = 0;

	always @(posedge clk) begin
		heading_t want;
		if (arst_n && heading_valid === 1'b1 && !heading_stall) begin
			if (pending_headings.size() == 0) begin
				report_mismatch("heading with none pending", int'(heading_deg), -1);
			end else begin
				want = pending_headings.pop_front();
				headings_checked++;
				if (heading_deg !== want.heading)
					report_mismatch("heading_deg", int'(heading_deg),
					                int'(want.heading));
				if (direction_code !== want.sector)
					report_mismatch("direction_code", int'(direction_code),
					                int'(want.sector));
			end
		end
		rx_cycle++;
		stall_left--;
		if (stall_left <= 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(50, 400);
		end
		case (stall_mode)
			STALL_OFF:    heading_stall <= 1'b0;
			STALL_SPARSE: heading_stall <= ($urandom_range(0, 9) == 0);
			STALL_HEAVY:  heading_stall <= ($urandom_range(0, 3) != 0);
			default:      heading_stall <= (rx_cycle[3:0] >= 4'd8);
		endcase
	end

	// ---------------------------------------------------------------- drivers

	// one sample transfer; bursts of random length with a random gap after most of them
	task automatic send_sample(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys);
		if (!valid_on) begin
			sample_valid <= 1'b1;
			valid_on = 1'b1;
		end
		x_sample <= xs;
		y_sample <= ys;
		do @(posedge clk); while (sample_stall);
		pending_headings.push_back(predict_heading(xs, ys));
		samples_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				sample_valid <= 1'b0;
				valid_on = 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	endtask

	// drop valid and let every pending heading arrive
	task automatic wait_idle();
		if (valid_on) begin
			sample_valid <= 1'b0;
			valid_on = 1'b0;
		end
		do @(posedge clk); while (pending_headings.size() != 0);
	endtask

	task automatic write_declination(input int deg);
		wait_idle();
		cfg_valid       <= 1'b1;
		declination_deg <= chc_pkg::DECL_BITS'(deg);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		declination_model = deg;
		decl_writes++;
	endtask

	// ---------------------------------------------------------------- tests

	// right after reset: zero offsets, pure-axis offsets, the 360 wrap and three
	// quadrants (none with x and y both under their midpoints), all with the reset declination
	task automatic test_reset_state_cases();
		send_sample(16'h8000, 16'h8000);    // both offsets zero
		send_sample(16'h8000, 16'h9000);    // zero x offset, raw heading of 360
		send_sample(16'h8000, 16'h7000);
		send_sample(16'h7000, 16'h8000);    // zero y offset
		send_sample(16'h9000, 16'h9000);
		send_sample(16'h9000, 16'h7000);
		send_sample(16'h7000, 16'h9000);
	endtask

	// declination extremes, in range and out to the full register width
	task automatic test_declination_values();
		int decl_set [6] = '{-180, 180, 0, -256, 255, -1};
		int k;
		for (k = 0; k < 6; k++) begin
			write_declination(decl_set[k]);
			send_sample(16'h8C00, 16'h7400);
			send_sample(16'h7400, 16'h8C00);
		end
	endtask

	// calibration range grows slowly; some samples sit exactly on a midpoint
	task automatic test_random_widening();
		int          i, w, kind;
		logic [SAMPLE_W-1:0] xs, ys;
		write_declination(15);
		for (i = 0; i < 600; i++) begin
			w    = 8 + i * 55;
			if (w > 32767)
				w = 32767;
			kind = $urandom_range(0, 19);
			xs   = SAMPLE_W'(32768 + $urandom_range(0, 2 * w) - w);
			ys   = SAMPLE_W'(32768 + $urandom_range(0, 2 * w) - w);
			if (kind < 3)
				xs = (x_max >> 1) + (x_min >> 1);
			else if (kind < 6)
				ys = (y_max >> 1) + (y_min >> 1);
			send_sample(xs, ys);
			if (i % 150 == 149)
				write_declination($urandom_range(0, 360) - 180);
		end
	endtask

	// field extremes saturate the trackers; midpoint settles at 0x7FFF
	task automatic test_field_extremes();
		write_declination(0);
		send_sample(16'h0000, 16'h0000);
		send_sample(16'hFFFF, 16'hFFFF);
		send_sample(16'h0000, 16'hFFFF);
		send_sample(16'hFFFF, 16'h0000);
		send_sample(16'h7FFF, 16'h7FFF);
		send_sample(16'h7FFF, 16'h0000);
		send_sample(16'h0000, 16'h7FFF);
	endtask

	// full-range samples in chunks, a fresh declination between chunks
	task automatic test_random_full_range();
		int chunk, i, kind, d;
		logic [SAMPLE_W-1:0] xs, ys;
		for (chunk = 0; chunk < 5; chunk++) begin
			case (chunk)
				0:       write_declination(-256);
				1:       write_declination(255);
				default: write_declination($urandom_range(0, 511) - 256);
			endcase
			for (i = 0; i < 250; i++) begin
				kind = $urandom_range(0, 9);
				xs   = SAMPLE_W'($urandom_range(0, 16'hFFFF));
				ys   = SAMPLE_W'($urandom_range(0, 16'hFFFF));
				d    = $urandom_range(0, 16'h7FFF);
				case (kind)
					4: xs = 16'h7FFF;                               // zero x offset
					5: ys = 16'h7FFF;                               // zero y offset
					6: begin                                        // near center
						xs = SAMPLE_W'(16'h7FFF + $urandom_range(0, 128) - 64);
						ys = SAMPLE_W'(16'h7FFF + $urandom_range(0, 128) - 64);
					end
					7: begin                                        // diagonal
						xs = $urandom_range(0, 1) ? SAMPLE_W'(16'h7FFF + d)
						                          : SAMPLE_W'(16'h7FFF - d);
						ys = $urandom_range(0, 1) ? SAMPLE_W'(16'h7FFF + d)
						                          : SAMPLE_W'(16'h7FFF - d);
					end
					default: ;
				endcase
				send_sample(xs, ys);
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		x_max = CENTER;
		x_min = CENTER;
		y_max = CENTER;
		y_min = CENTER;
		declination_model = 15;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state_cases();
		test_declination_values();
		test_random_widening();
		test_field_extremes();
		test_random_full_range();

		wait_idle();
		repeat (DRAIN_CYC) @(posedge clk);
		if (pending_headings.size() != 0)
			report_mismatch("headings never delivered", 0, pending_headings.size());

		$display("Sent %0d sample pairs, checked %0d headings, %0d declination writes,",
		         samples_sent, headings_checked, decl_writes);
		$display("covering zero offsets, the 360 wrap, all quadrants and range growth.");
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* compass_heading_with_calibration.f */
hw/rtl/chc_pkg.sv
hw/rtl/chc_calib.sv
hw/rtl/chc_cordic.sv
hw/rtl/compass_heading_with_calibration.sv
dv/compass_heading_with_calibration_test.sv
